// ===== hdl/l2vn_pkg.sv =====
`timescale 1ns / 1ps

package l2vn_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int SAMPLE_W    = 8;
    localparam int SUM_W       = 21;
    localparam int K_W         = 7;
    localparam int KSQ_W       = 14;
    localparam int BOUND_W     = 30;
    localparam int PROD_W      = KSQ_W + SUM_W;
    localparam int BIT_W       = 3;
    localparam int STEP_W      = 3;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_READ,
        OP_INIT,
        OP_MUL,
        OP_CMP,
        OP_EMIT,
        OP_DONE
    } op_t;

    typedef enum logic [1:0] {
        C_NEXT,
        C_GOTO,
        C_LOOP,
        C_MORE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic hold;
        logic bit_nz;
        logic more;
    } stat_t;

    localparam step_t ST_LOAD = 3'd0;
    localparam step_t ST_READ = 3'd1;
    localparam step_t ST_INIT = 3'd2;
    localparam step_t ST_MUL  = 3'd3;
    localparam step_t ST_CMP  = 3'd4;
    localparam step_t ST_EMIT = 3'd5;
    localparam step_t ST_DONE = 3'd6;

    // Microprogram: one control word per step.
    function automatic ctrl_t rom_word(input step_t step);
        ctrl_t w;
        case (step)
            ST_LOAD: w = '{op: OP_LOAD, cond: C_NEXT, target: ST_LOAD};
            ST_READ: w = '{op: OP_READ, cond: C_NEXT, target: ST_LOAD};
            ST_INIT: w = '{op: OP_INIT, cond: C_NEXT, target: ST_LOAD};
            ST_MUL:  w = '{op: OP_MUL,  cond: C_NEXT, target: ST_LOAD};
            ST_CMP:  w = '{op: OP_CMP,  cond: C_LOOP, target: ST_MUL};
            ST_EMIT: w = '{op: OP_EMIT, cond: C_MORE, target: ST_READ};
            ST_DONE: w = '{op: OP_DONE, cond: C_GOTO, target: ST_LOAD};
            default: w = '{op: OP_DONE, cond: C_GOTO, target: ST_LOAD};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/l2vn_if.sv =====
`timescale 1ns / 1ps

interface l2vn_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [l2vn_pkg::SAMPLE_W-1:0] sample;
    logic                              last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

interface l2vn_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [l2vn_pkg::SAMPLE_W-1:0] value;
    logic                              final_res;
    logic                              zero_norm;
    logic                              overflow;

    modport source (output valid, output value, output final_res, output zero_norm,
                    output overflow, input ready);
    modport sink (input valid, input value, input final_res, input zero_norm,
                  input overflow, output ready);
endinterface

// ===== hdl/l2_vector_normalizer_q7.sv =====
`timescale 1ns / 1ps

// L2 normalizer for a vector of signed Q7 samples. Samples are taken one item per cycle
// until an item marked last, up to MAX_LEN of them; later samples are dropped and every
// result of that run carries overflow. Each stored sample q is then emitted, in order, as
// sign(q) times the largest k of at most 127 with k*k*S <= 16384*q*q, S being the sum of
// squares; an all-zero vector gives zeros with zero_norm set. Each result comes from a
// seven-step bit search, a MUL and a CMP step per bit, through one 14 by 21 bit multiplier,
// and each run ends with a DONE step that clears the run state before the next vector is
// taken. The output register holds a result until it is taken, while the search goes on.
module l2_vector_normalizer_q7 #(
    parameter int MAX_LEN = l2vn_pkg::MAX_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    l2vn_in_if.sink    vec_in,
    l2vn_out_if.source vec_out
);

    l2vn_pkg::step_t step_reg;
    l2vn_pkg::step_t step_next;
    l2vn_pkg::ctrl_t ctrl;
    l2vn_pkg::stat_t stat;

    assign ctrl = l2vn_pkg::rom_word(step_reg);

    always_comb
    begin
        step_next = step_reg + l2vn_pkg::STEP_W'(1);
        if (stat.hold)
        begin
            step_next = step_reg;
        end
        else
        begin
            case (ctrl.cond)
                l2vn_pkg::C_NEXT: step_next = step_reg + l2vn_pkg::STEP_W'(1);
                l2vn_pkg::C_GOTO: step_next = ctrl.target;
                l2vn_pkg::C_LOOP:
                    step_next = stat.bit_nz ? ctrl.target : step_reg + l2vn_pkg::STEP_W'(1);
                l2vn_pkg::C_MORE:
                    step_next = stat.more ? ctrl.target : step_reg + l2vn_pkg::STEP_W'(1);
                default:          step_next = l2vn_pkg::ST_LOAD;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= l2vn_pkg::ST_LOAD;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    l2vn_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (ctrl.op),
        .stat    (stat),
        .vec_in  (vec_in),
        .vec_out (vec_out)
    );

endmodule

// ===== hdl/l2vn_datapath.sv =====
`timescale 1ns / 1ps

module l2vn_datapath #(
    parameter int MAX_LEN = l2vn_pkg::MAX_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  l2vn_pkg::op_t       op,
    output l2vn_pkg::stat_t     stat,
    l2vn_in_if.sink             vec_in,
    l2vn_out_if.source          vec_out
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SW     = l2vn_pkg::SAMPLE_W;
    localparam int SUMW   = l2vn_pkg::SUM_W;
    localparam int KW     = l2vn_pkg::K_W;
    localparam int KSQW   = l2vn_pkg::KSQ_W;
    localparam int BNDW   = l2vn_pkg::BOUND_W;
    localparam int PRODW  = l2vn_pkg::PROD_W;
    localparam int BITW   = l2vn_pkg::BIT_W;

    logic [SW-1:0]     mem [MAX_LEN];
    logic [SW-1:0]     rd_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SUMW-1:0]   sum_reg;
    logic              ovf_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic              neg_reg;
    logic [BNDW-1:0]   bound_reg;
    logic [KW-1:0]     k_reg;
    logic [KSQW-1:0]   ksq_reg;
    logic [KSQW-1:0]   tsq_reg;
    logic [BITW-1:0]   bit_reg;
    logic [PRODW-1:0]  prod_reg;
    logic              out_valid_reg;
    logic [SW-1:0]     value_reg;
    logic              final_reg;
    logic              zero_reg;
    logic              ovf_out_reg;

    logic              in_fire;
    logic              room;
    logic [SW-1:0]     in_raw;
    logic [SW-1:0]     in_mag;
    logic [2*SW-1:0]   in_sq;
    logic [SW-1:0]     rd_mag;
    logic [2*SW-1:0]   rd_sq;
    logic [KW-1:0]     t_c;
    logic [KSQW-1:0]   tsq_c;
    logic              out_free;
    logic              is_last_elem;
    logic [SW-1:0]     k_ext;
    logic [SW-1:0]     value_c;

    assign vec_in.ready = (op == l2vn_pkg::OP_LOAD);
    assign in_fire      = vec_in.valid && vec_in.ready;
    assign room         = (count_reg < CNT_W'(MAX_LEN));
    assign in_raw       = vec_in.sample;
    assign in_mag       = in_raw[SW-1] ? (~in_raw + SW'(1)) : in_raw;
    assign in_sq        = in_mag * in_mag;
    assign rd_mag       = rd_reg[SW-1] ? (~rd_reg + SW'(1)) : rd_reg;
    assign rd_sq        = rd_mag * rd_mag;

    // Squares of successive trial values are built by shift and add.
    assign t_c   = k_reg | (KW'(1) << bit_reg);
    assign tsq_c = ksq_reg + (KSQW'(k_reg) << (bit_reg + BITW'(1)))
                 + (KSQW'(1) << {bit_reg, 1'b0});

    assign out_free     = !out_valid_reg || vec_out.ready;
    assign is_last_elem = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));
    assign k_ext        = {1'b0, k_reg};
    assign value_c      = (sum_reg == '0) ? '0 : (neg_reg ? (SW'(0) - k_ext) : k_ext);

    always_comb
    begin
        stat.hold   = 1'b0;
        stat.bit_nz = (bit_reg != '0);
        stat.more   = !is_last_elem;
        case (op)
            l2vn_pkg::OP_LOAD: stat.hold = !(in_fire && vec_in.last);
            l2vn_pkg::OP_EMIT: stat.hold = !out_free;
            default:           stat.hold = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && room)
        begin
            mem[count_reg[ADDR_W-1:0]] <= in_raw;
        end
        if (op == l2vn_pkg::OP_READ)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            neg_reg       <= 1'b0;
            bound_reg     <= '0;
            k_reg         <= '0;
            ksq_reg       <= '0;
            tsq_reg       <= '0;
            bit_reg       <= '0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            value_reg     <= '0;
            final_reg     <= 1'b0;
            zero_reg      <= 1'b0;
            ovf_out_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && vec_out.ready && (op != l2vn_pkg::OP_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                l2vn_pkg::OP_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (room)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                            sum_reg   <= sum_reg + SUMW'(in_sq);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (vec_in.last)
                        begin
                            idx_reg <= '0;
                        end
                    end
                end
                l2vn_pkg::OP_INIT:
                begin
                    neg_reg   <= rd_reg[SW-1];
                    bound_reg <= BNDW'(rd_sq) << 14;
                    k_reg     <= '0;
                    ksq_reg   <= '0;
                    bit_reg   <= BITW'(KW - 1);
                end
                l2vn_pkg::OP_MUL:
                begin
                    tsq_reg  <= tsq_c;
                    prod_reg <= tsq_c * sum_reg;
                end
                l2vn_pkg::OP_CMP:
                begin
                    if (prod_reg <= PRODW'(bound_reg))
                    begin
                        k_reg   <= t_c;
                        ksq_reg <= tsq_reg;
                    end
                    if (bit_reg != '0)
                    begin
                        bit_reg <= bit_reg - BITW'(1);
                    end
                end
                l2vn_pkg::OP_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        value_reg     <= value_c;
                        final_reg     <= is_last_elem;
                        zero_reg      <= (sum_reg == '0);
                        ovf_out_reg   <= ovf_reg;
                        idx_reg       <= idx_reg + ADDR_W'(1);
                    end
                    else
                    begin
                        out_valid_reg <= out_valid_reg;
                    end
                end
                l2vn_pkg::OP_DONE:
                begin
                    count_reg <= '0;
                    sum_reg   <= '0;
                    ovf_reg   <= 1'b0;
                    idx_reg   <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign vec_out.valid     = out_valid_reg;
    assign vec_out.value     = value_reg;
    assign vec_out.final_res = final_reg;
    assign vec_out.zero_norm = zero_reg;
    assign vec_out.overflow  = ovf_out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LEN))
        else $error("Element count exceeds the store depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        ksq_reg == KSQW'(k_reg) * KSQW'(k_reg))
        else $error("Running square does not match the search value.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (sum_reg == '0) && !ovf_reg)
        else $error("Run state is not clear while the store is empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (vec_out.valid && vec_out.zero_norm) |-> (vec_out.value == '0))
        else $error("Zero-norm item carries a nonzero value.");

endmodule
